FILE: src/ccd_egc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_egc_pkg
// Shared types, constants and the grade lookup for the CCD event grade
// classifier.
// ----------------------------------------------------------------------------
package ccd_egc_pkg;

  // field widths
  localparam int PixW    = 16;
  localparam int PosW    = 12;
  localparam int GradeW  = 3;
  localparam int PhW     = 12;
  localparam int TotW    = 20;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 3;
  localparam int NumPix  = 9;

  // pulse-height window upper bound (exclusive)
  localparam int AduRange = 4096;

  // queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegEventThr  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSplitThr  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTotalMode = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCorrStyle = 3'd3;
  localparam logic [CfgIdxW-1:0] RegResetFac  = 3'd4;

  // reset-clock correction styles
  localparam logic [1:0] CorrNone  = 2'd0;
  localparam logic [1:0] CorrOne   = 2'd1;
  localparam logic [1:0] CorrThree = 2'd2;
  localparam logic [1:0] CorrSix   = 2'd3;

  // pixel total modes
  localparam logic [2:0] ModeAll   = 3'd0;
  localparam logic [2:0] ModeVert  = 3'd1;
  localparam logic [2:0] ModeHoriz = 3'd2;
  localparam logic [2:0] ModeCross = 3'd3;
  localparam logic [2:0] ModeNone  = 3'd4;

  // grades
  localparam logic [GradeW-1:0] GradeSingle      = 3'd0;
  localparam logic [GradeW-1:0] GradeSingleCorn  = 3'd1;
  localparam logic [GradeW-1:0] GradeVertSplit   = 3'd2;
  localparam logic [GradeW-1:0] GradeLeftSplit   = 3'd3;
  localparam logic [GradeW-1:0] GradeRightSplit  = 3'd4;
  localparam logic [GradeW-1:0] GradeSplitCorn   = 3'd5;
  localparam logic [GradeW-1:0] GradeLSquare     = 3'd6;
  localparam logic [GradeW-1:0] GradeOther       = 3'd7;

  // split-map masks for the corner inside an L-shaped event
  localparam logic [7:0] EdgeMask = 8'h5a;
  localparam logic [7:0] CornerTl = 8'h0a;
  localparam logic [7:0] CornerTr = 8'h12;
  localparam logic [7:0] CornerBl = 8'h48;
  localparam logic [7:0] CornerBr = 8'h50;

  typedef struct packed {
    logic signed [PixW-1:0] pix0;
    logic signed [PixW-1:0] pix1;
    logic signed [PixW-1:0] pix2;
    logic signed [PixW-1:0] pix3;
    logic signed [PixW-1:0] pix4;
    logic signed [PixW-1:0] pix5;
    logic signed [PixW-1:0] pix6;
    logic signed [PixW-1:0] pix7;
    logic signed [PixW-1:0] pix8;
    logic [PosW-1:0]        pos_x;
    logic [PosW-1:0]        pos_y;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]        out_x;
    logic [PosW-1:0]        out_y;
    logic [GradeW-1:0]      grade;
    logic [PhW-1:0]         pulse_height;
    logic signed [PixW-1:0] centre_value;
    logic signed [TotW-1:0] mode_total;
  } out_item_t;

  typedef struct packed {
    logic signed [PixW-1:0] event_thr;
    logic signed [PixW-1:0] split_thr;
    logic [2:0]             total_mode;
    logic [1:0]             corr_style;
    logic signed [PixW-1:0] reset_factor;
  } cfg_t;

  // corrected window travelling through the queue
  typedef struct packed {
    logic [NumPix-1:0][PixW-1:0] px;
    logic [PosW-1:0]             pos_x;
    logic [PosW-1:0]             pos_y;
  } pix_item_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [FifoPtrW:0]   count;
  } fifo_stat_t;

  // exclusive grade table, anything not listed is grade other
  function automatic logic [GradeW-1:0] grade_of(input logic [7:0] map);
    logic [GradeW-1:0] g;
    case (map)
      8'h00: g = GradeSingle;
      8'h01, 8'h04, 8'h20, 8'h80, 8'h05, 8'h21, 8'h81, 8'h24,
      8'h84, 8'ha0, 8'h25, 8'h85, 8'ha4, 8'ha1, 8'ha5: g = GradeSingleCorn;
      8'h02, 8'h40, 8'h22, 8'h82, 8'h41, 8'h44, 8'h45, 8'ha2: g = GradeVertSplit;
      8'h08, 8'h0c, 8'h88, 8'h8c: g = GradeLeftSplit;
      8'h10, 8'h30, 8'h11, 8'h31: g = GradeRightSplit;
      8'h03, 8'h06, 8'h09, 8'h28, 8'h60, 8'hc0, 8'h90, 8'h14,
      8'h83, 8'h26, 8'h89, 8'h2c, 8'h64, 8'hc1, 8'h91, 8'h34,
      8'h23, 8'h86, 8'h0d, 8'ha8, 8'h61, 8'hc4, 8'hb0, 8'h15,
      8'ha3, 8'ha6, 8'h8d, 8'hac, 8'h65, 8'hc5, 8'hb1, 8'h35: g = GradeSplitCorn;
      8'h12, 8'h32, 8'h50, 8'h51, 8'h48, 8'h4c, 8'h0a, 8'h8a,
      8'h16, 8'hd0, 8'h68, 8'h0b, 8'h36, 8'hd1, 8'h6c, 8'h8b: g = GradeLSquare;
      default: g = GradeOther;
    endcase
    return g;
  endfunction

  // pixels summed into the mode total, bit j selects pixel j
  function automatic logic [NumPix-1:0] mode_mask(input logic [2:0] mode);
    logic [NumPix-1:0] m;
    case (mode)
      ModeAll:   m = 9'h1ff;
      ModeVert:  m = 9'h092;
      ModeHoriz: m = 9'h038;
      ModeCross: m = 9'h0ba;
      ModeNone:  m = 9'h000;
      default:   m = 9'h000;
    endcase
    return m;
  endfunction

endpackage

FILE: src/ccd_egc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_egc_front
// Accepts event windows, drops those under the event threshold and applies
// the reset-clock correction in three pipeline stages.
// ----------------------------------------------------------------------------
module ccd_egc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ccd_egc_pkg::cfg_t      cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ccd_egc_pkg::in_item_t  in_data,
  output logic                   wr_valid,
  input  logic                   wr_ready,
  output ccd_egc_pkg::pix_item_t wr_data
);

  // saturate a truncated value to the pixel range
  function automatic logic signed [15:0] sat16(input logic signed [18:0] t);
    logic signed [15:0] r;
    if (t > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (t < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  // value in units of 2^-15, truncated toward zero
  function automatic logic signed [15:0] trunc_q(input logic signed [31:0] q);
    logic signed [18:0] t;
    t = 19'($signed(q[31:15]));
    if (q[31] && (q[14:0] != 15'd0)) begin
      t = t + 19'sd1;
    end
    return sat16(t);
  endfunction

  // value in units of 2^-30, truncated toward zero
  function automatic logic signed [15:0] trunc_v(input logic signed [48:0] v);
    logic signed [18:0] t;
    t = v[48:30];
    if (v[48] && (v[29:0] != 30'd0)) begin
      t = t + 19'sd1;
    end
    return sat16(t);
  endfunction

  logic                  keep_w;
  logic                  six_w;
  logic                  three_w;
  logic                  one_w;
  logic                  s2_ready;
  logic                  s3_ready;

  logic                  s1_v_r;
  ccd_egc_pkg::in_item_t s1_d_r;
  logic signed [31:0]    s1_m0_r;
  logic signed [31:0]    s1_m3_r;
  logic signed [31:0]    s1_m6_r;

  logic signed [32:0]    q1_w;
  logic signed [32:0]    q4_w;
  logic signed [32:0]    q7_w;

  logic                  s2_v_r;
  ccd_egc_pkg::in_item_t s2_d_r;
  logic signed [31:0]    s2_q1_r;
  logic signed [31:0]    s2_q4_r;
  logic signed [31:0]    s2_q7_r;

  logic                  s3_v_r;
  ccd_egc_pkg::in_item_t s3_d_r;
  logic signed [31:0]    s3_q1_r;
  logic signed [31:0]    s3_q4_r;
  logic signed [31:0]    s3_q7_r;
  logic signed [47:0]    s3_n2_r;
  logic signed [47:0]    s3_n5_r;
  logic signed [47:0]    s3_n8_r;

  logic signed [48:0]    v2_w;
  logic signed [48:0]    v5_w;
  logic signed [48:0]    v8_w;

  // stall chain, each stage takes when empty or when it drains
  assign s3_ready = !s3_v_r || wr_ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign in_ready = !s1_v_r || s2_ready;

  assign keep_w  = in_data.pix4 >= cfg.event_thr;
  assign six_w   = cfg.corr_style == ccd_egc_pkg::CorrSix;
  assign three_w = (cfg.corr_style == ccd_egc_pkg::CorrThree) || six_w;
  assign one_w   = (cfg.corr_style == ccd_egc_pkg::CorrOne) || three_w;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid && keep_w;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_ready) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  // stage 1: first-level products neighbour * factor
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_d_r  <= in_data;
      s1_m0_r <= 32'(in_data.pix0) * 32'(cfg.reset_factor);
      s1_m3_r <= 32'(in_data.pix3) * 32'(cfg.reset_factor);
      s1_m6_r <= 32'(in_data.pix6) * 32'(cfg.reset_factor);
    end
  end

  // stage 2: sources of the second level in units of 2^-15
  assign q1_w = (33'(s1_d_r.pix1) <<< 15) - (six_w ? 33'(s1_m0_r) : 33'sd0);
  assign q4_w = (33'(s1_d_r.pix4) <<< 15) - (six_w ? 33'(s1_m3_r) : 33'sd0);
  assign q7_w = (33'(s1_d_r.pix7) <<< 15) - (six_w ? 33'(s1_m6_r) : 33'sd0);

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_d_r  <= s1_d_r;
      s2_q1_r <= q1_w[31:0];
      s2_q4_r <= q4_w[31:0];
      s2_q7_r <= q7_w[31:0];
    end
  end

  // stage 3: second-level products source * factor
  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_d_r  <= s2_d_r;
      s3_q1_r <= s2_q1_r;
      s3_q4_r <= s2_q4_r;
      s3_q7_r <= s2_q7_r;
      s3_n2_r <= 48'(s2_q1_r) * 48'(cfg.reset_factor);
      s3_n5_r <= 48'(s2_q4_r) * 48'(cfg.reset_factor);
      s3_n8_r <= 48'(s2_q7_r) * 48'(cfg.reset_factor);
    end
  end

  // corrected values in units of 2^-30
  assign v2_w = (49'(s3_d_r.pix2) <<< 30) - 49'(s3_n2_r);
  assign v5_w = (49'(s3_d_r.pix5) <<< 30) - 49'(s3_n5_r);
  assign v8_w = (49'(s3_d_r.pix8) <<< 30) - 49'(s3_n8_r);

  // truncate and saturate into the queue transaction
  always_comb begin
    wr_valid         = s3_v_r;
    wr_data.pos_x    = s3_d_r.pos_x;
    wr_data.pos_y    = s3_d_r.pos_y;
    wr_data.px[0]    = s3_d_r.pix0;
    wr_data.px[3]    = s3_d_r.pix3;
    wr_data.px[6]    = s3_d_r.pix6;
    wr_data.px[1]    = six_w ? trunc_q(s3_q1_r) : s3_d_r.pix1;
    wr_data.px[4]    = six_w ? trunc_q(s3_q4_r) : s3_d_r.pix4;
    wr_data.px[7]    = six_w ? trunc_q(s3_q7_r) : s3_d_r.pix7;
    wr_data.px[2]    = three_w ? trunc_v(v2_w) : s3_d_r.pix2;
    wr_data.px[8]    = three_w ? trunc_v(v8_w) : s3_d_r.pix8;
    wr_data.px[5]    = one_w ? trunc_v(v5_w) : s3_d_r.pix5;
  end

endmodule

FILE: src/ccd_egc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_egc_fifo
// Short queue of corrected windows between the front and the back.
// ----------------------------------------------------------------------------
module ccd_egc_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_valid,
  output logic                    wr_ready,
  input  ccd_egc_pkg::pix_item_t  wr_data,
  output logic                    rd_valid,
  input  logic                    rd_ready,
  output ccd_egc_pkg::pix_item_t  rd_data,
  output ccd_egc_pkg::fifo_stat_t stat
);

  localparam int PtrW = ccd_egc_pkg::FifoPtrW;
  localparam logic [PtrW:0] Full = (PtrW + 1)'(ccd_egc_pkg::FifoDepth);

  ccd_egc_pkg::pix_item_t mem_r [ccd_egc_pkg::FifoDepth];
  logic [PtrW-1:0]        wr_ptr_r;
  logic [PtrW-1:0]        rd_ptr_r;
  logic [PtrW:0]          cnt_r;
  logic                   push_w;
  logic                   pop_w;

  assign wr_ready = cnt_r != Full;
  assign rd_valid = cnt_r != '0;
  assign push_w   = wr_valid && wr_ready;
  assign pop_w    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  assign stat.full  = !wr_ready;
  assign stat.empty = !rd_valid;
  assign stat.count = cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_w) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_w) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_w && !pop_w) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_w && !push_w) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_w) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: src/ccd_egc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_egc_back
// Builds the split map, looks up the grade, forms pulse height and mode
// total, and holds the result in the output register.
// ----------------------------------------------------------------------------
module ccd_egc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ccd_egc_pkg::cfg_t      cfg,
  input  logic                   rd_valid,
  output logic                   rd_ready,
  input  ccd_egc_pkg::pix_item_t rd_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ccd_egc_pkg::out_item_t out_data
);

  localparam int NumPix = ccd_egc_pkg::NumPix;
  localparam int PixW   = ccd_egc_pkg::PixW;
  localparam int TotW   = ccd_egc_pkg::TotW;
  localparam logic signed [TotW-1:0] AduLimit = TotW'(ccd_egc_pkg::AduRange);

  logic signed [PixW-1:0]           px_w [NumPix];
  logic signed [PixW-1:0]           ph_w [NumPix];
  logic [NumPix-1:0]                hit_w;
  logic [7:0]                       map_w;
  logic [ccd_egc_pkg::GradeW-1:0]   grade_w;
  logic signed [PixW-1:0]           corner_w;
  logic [NumPix-1:0]                sel_w;
  logic signed [17:0]               pa_w;
  logic signed [17:0]               pb_w;
  logic signed [18:0]               ta_w;
  logic signed [18:0]               tb_w;

  logic                             b1_v_r;
  logic [ccd_egc_pkg::PosW-1:0]     b1_x_r;
  logic [ccd_egc_pkg::PosW-1:0]     b1_y_r;
  logic [ccd_egc_pkg::GradeW-1:0]   b1_grade_r;
  logic signed [PixW-1:0]           b1_centre_r;
  logic signed [17:0]               b1_pa_r;
  logic signed [17:0]               b1_pb_r;
  logic signed [18:0]               b1_ta_r;
  logic signed [18:0]               b1_tb_r;

  logic signed [TotW-1:0]           sum_w;
  logic signed [TotW-1:0]           tot_w;
  logic                             in_range_w;
  logic                             out_room_w;

  logic                             out_valid_r;
  ccd_egc_pkg::out_item_t           out_data_r;

  // split map and grade
  always_comb begin
    for (int j = 0; j < NumPix; j++) begin
      px_w[j]  = rd_data.px[j];
      hit_w[j] = px_w[j] >= cfg.split_thr;
      ph_w[j]  = hit_w[j] ? px_w[j] : '0;
    end
    map_w   = {hit_w[8], hit_w[7], hit_w[6], hit_w[5],
               hit_w[3], hit_w[2], hit_w[1], hit_w[0]};
    grade_w = ccd_egc_pkg::grade_of(map_w);
  end

  // corner inside the L for grade six
  always_comb begin
    corner_w = '0;
    if (grade_w == ccd_egc_pkg::GradeLSquare) begin
      case (map_w & ccd_egc_pkg::EdgeMask)
        ccd_egc_pkg::CornerTl: corner_w = ph_w[0];
        ccd_egc_pkg::CornerTr: corner_w = ph_w[2];
        ccd_egc_pkg::CornerBl: corner_w = ph_w[6];
        ccd_egc_pkg::CornerBr: corner_w = ph_w[8];
        default:               corner_w = '0;
      endcase
    end
  end

  // partial sums for pulse height and mode total
  always_comb begin
    sel_w = ccd_egc_pkg::mode_mask(cfg.total_mode);
    pa_w  = 18'(px_w[4]) + 18'(ph_w[1]) + 18'(ph_w[3]);
    pb_w  = 18'(ph_w[5]) + 18'(ph_w[7]) + 18'(corner_w);
    ta_w  = '0;
    tb_w  = '0;
    for (int j = 0; j < 5; j++) begin
      if (sel_w[j]) begin
        ta_w = ta_w + 19'(px_w[j]);
      end
    end
    for (int j = 5; j < NumPix; j++) begin
      if (sel_w[j]) begin
        tb_w = tb_w + 19'(px_w[j]);
      end
    end
  end

  // final sums and range check
  assign sum_w      = TotW'(b1_pa_r) + TotW'(b1_pb_r);
  assign tot_w      = TotW'(b1_ta_r) + TotW'(b1_tb_r);
  assign in_range_w = (sum_w >= 0) && (sum_w < AduLimit);

  // handshake
  assign out_room_w = !out_valid_r || out_ready;
  assign rd_ready   = !b1_v_r || out_room_w;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rd_ready) begin
        b1_v_r <= rd_valid;
      end
      if (out_room_w) begin
        out_valid_r <= b1_v_r && in_range_w;
      end
    end
  end

  // grade stage payload
  always_ff @(posedge clk) begin
    if (rd_ready) begin
      b1_x_r      <= rd_data.pos_x;
      b1_y_r      <= rd_data.pos_y;
      b1_grade_r  <= grade_w;
      b1_centre_r <= px_w[4];
      b1_pa_r     <= pa_w;
      b1_pb_r     <= pb_w;
      b1_ta_r     <= ta_w;
      b1_tb_r     <= tb_w;
    end
  end

  // output register, out-of-range sums leave no transaction
  always_ff @(posedge clk) begin
    if (out_room_w && b1_v_r && in_range_w) begin
      out_data_r.out_x        <= b1_x_r;
      out_data_r.out_y        <= b1_y_r;
      out_data_r.grade        <= b1_grade_r;
      out_data_r.pulse_height <= sum_w[ccd_egc_pkg::PhW-1:0];
      out_data_r.centre_value <= b1_centre_r;
      out_data_r.mode_total   <= tot_w;
    end
  end

endmodule

FILE: src/ccd_event_grade_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_event_grade_classifier
// 3x3 CCD event grading: event threshold, reset-clock correction, split map,
// grade lookup, pulse height and selectable pixel total.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in_      in   in_valid / in_ready   in_data   (pixels, position)
//  out_     out  out_valid / out_ready out_data  (position, grade, sums)
//  cfg_     in   cfg_we                cfg_index, cfg_wdata
//
//  One event per cycle sustained while out_ready is high; the path runs
//  through three front stages (two multiplier levels of the correction
//  chain), the queue, the grade stage and the output register.
//  Reset is synchronous on rst_n low: valid flags and queue pointers clear,
//  registers return to 0, 0, 0, 1, 0.
//  A stalled output fills the output register, grade stage, the four-entry
//  queue and then the front stages; in_ready drops only once all are full.
//  Events below threshold or with pulse height outside 0..4095 give nothing.
// ----------------------------------------------------------------------------
module ccd_event_grade_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ccd_egc_pkg::in_item_t               in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ccd_egc_pkg::out_item_t              out_data,
  input  logic                                cfg_we,
  input  logic [ccd_egc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [ccd_egc_pkg::CfgW-1:0]        cfg_wdata
);

  ccd_egc_pkg::cfg_t       cfg_r;
  logic                    f_valid;
  logic                    f_ready;
  ccd_egc_pkg::pix_item_t  f_data;
  logic                    q_valid;
  logic                    q_ready;
  ccd_egc_pkg::pix_item_t  q_data;
  ccd_egc_pkg::fifo_stat_t q_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.event_thr    <= '0;
      cfg_r.split_thr    <= '0;
      cfg_r.total_mode   <= ccd_egc_pkg::ModeAll;
      cfg_r.corr_style   <= ccd_egc_pkg::CorrOne;
      cfg_r.reset_factor <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ccd_egc_pkg::RegEventThr:  cfg_r.event_thr    <= cfg_wdata;
        ccd_egc_pkg::RegSplitThr:  cfg_r.split_thr    <= cfg_wdata;
        ccd_egc_pkg::RegTotalMode: cfg_r.total_mode   <= cfg_wdata[2:0];
        ccd_egc_pkg::RegCorrStyle: cfg_r.corr_style   <= cfg_wdata[1:0];
        ccd_egc_pkg::RegResetFac:  cfg_r.reset_factor <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // threshold and correction
  ccd_egc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data)
  );

  // decoupling queue
  ccd_egc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data),
    .stat     (q_stat)
  );

  // grading and output
  ccd_egc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rd_valid  (q_valid),
    .rd_ready  (q_ready),
    .rd_data   (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // input backpressure only when everything downstream is full
  a_ready_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_stat.full)
    else $error("input stalled while queue has room");

  // back drains the queue whenever the output is taken
  a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && out_ready) |-> q_ready)
    else $error("queue not drained with output ready");

  // fill count stays within the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= (ccd_egc_pkg::FifoPtrW + 1)'(ccd_egc_pkg::FifoDepth))
    else $error("queue fill count beyond depth");

endmodule
